// ===== design/gbse_pkg.sv =====
// gbse_pkg: shared constants, types and helpers of the glyph bitmap span expander
// used by the channel interfaces, the sequencer, the span unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package gbse_pkg;

  // metric limits; the field widths below are fixed by the item format
  localparam int unsigned MAX_GLYPH_COLS = 32;
  localparam int unsigned MAX_PAD_COLS   = 8;
  localparam int unsigned MAX_PAD_ROWS   = 15;

  localparam int unsigned SPAN_BITS = 48;
  localparam int unsigned ROW_BITS  = 32;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SCR_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_ROWS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] SCR_COLS_RST = 10'd400;
  localparam logic [CFG_DATA_W-1:0] SCR_ROWS_RST = 10'd240;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  // one span request from the sequencer to the span unit
  typedef struct packed {
    logic [10:0]         x0;
    logic [10:0]         y;
    logic [3:0]          lead;
    logic [5:0]          glyph;
    logic [3:0]          trail;
    logic [ROW_BITS-1:0] bits;
    logic                glyph_row;
    logic                invert;
    logic                done;
  } span_req_t;

  // top n bits of a span set, n up to SPAN_BITS
  function automatic logic [SPAN_BITS-1:0] top_ones(input logic [5:0] n);
    logic [SPAN_BITS-1:0] r;
    r = ~({SPAN_BITS{1'b1}} >> n);
    return r;
  endfunction

  // saturate a 4 bit padding count
  function automatic logic [3:0] clamp_pad(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    r = (v > hi) ? hi : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/gbse_if.sv =====
// gbse_if: valid/ready channel interfaces for header/row words, span words
// and configuration writes; widths come from gbse_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gbse_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [10:0]            pos_x;
  logic signed [10:0]            pos_y;
  logic [3:0]                    cols_before;
  logic [5:0]                    cols_glyph;
  logic [3:0]                    cols_after;
  logic [3:0]                    rows_above;
  logic [4:0]                    rows_glyph;
  logic [3:0]                    rows_below;
  logic                          reverse_video;
  logic [1:0]                    padding_flags;
  logic [gbse_pkg::ROW_BITS-1:0] row_bits;

  modport source (
    output valid, kind, pos_x, pos_y, cols_before, cols_glyph, cols_after,
           rows_above, rows_glyph, rows_below, reverse_video, padding_flags, row_bits,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, cols_before, cols_glyph, cols_after,
           rows_above, rows_glyph, rows_below, reverse_video, padding_flags, row_bits,
    output ready
  );
endinterface

interface gbse_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [10:0]             span_x;
  logic signed [10:0]             span_y;
  logic [5:0]                     span_width;
  logic [gbse_pkg::SPAN_BITS-1:0] span_pixels;
  logic [gbse_pkg::SPAN_BITS-1:0] write_mask;
  logic signed [11:0]             next_x;
  logic                           glyph_done;

  modport source (
    output valid, span_x, span_y, span_width, span_pixels, write_mask, next_x, glyph_done,
    input  ready
  );
  modport sink (
    input  valid, span_x, span_y, span_width, span_pixels, write_mask, next_x, glyph_done,
    output ready
  );
endinterface

interface gbse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gbse_pkg::CFG_IDX_W-1:0]  index;
  logic [gbse_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/glyph_bitmap_span_expander_unit.sv =====
// glyph_bitmap_span_expander_unit: top level with the screen size registers
// depends on gbse_pkg, gbse_if, gbse_sequencer and gbse_span_unit
//
// Channels: in_i takes header and bitmap-row words, out_o gives span words,
// cfg_i writes the visible column count (index 0) and the visible row count
// (index 1); other indexes are taken and ignored. cfg_i is always ready.
// A header word is taken, then one span leaves per cycle while out_o is ready for
// each blank row above (and below, when the glyph has no bitmap rows). A bitmap-row
// word is taken and then its span is issued (a stray one issues none); each blank
// row below then adds one span. A span appears on out_o the cycle after it is
// issued, from the output register of the span unit. The sequencer steps one
// row per cycle through the shared span unit while out_o does not stall.
// in_i is ready only while no spans of the previous word are left to issue.
// If out_o stalls, the pending span holds in the output register and the
// sequencer waits; nothing is dropped.
// Reset clears the glyph state, sets the visible columns to 400 and the
// visible rows to 240, and leaves out_o empty.
`timescale 1ns / 1ps
`default_nettype none

module glyph_bitmap_span_expander_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gbse_in_if.sink   in_i,
  gbse_cfg_if.sink  cfg_i,
  gbse_out_if.source out_o
);
  import gbse_pkg::*;

  logic [CFG_DATA_W-1:0] scr_cols_q, scr_rows_q;
  logic                  slot_free;
  logic                  issue;
  span_req_t             req;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_cols_q <= SCR_COLS_RST;
      scr_rows_q <= SCR_ROWS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SCR_COLS: scr_cols_q <= cfg_i.data;
        REG_SCR_ROWS: scr_rows_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  gbse_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .slot_free_i (slot_free),
    .issue_o     (issue),
    .req_o       (req)
  );

  gbse_span_unit u_span (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scr_cols_i  (scr_cols_q),
    .scr_rows_i  (scr_rows_q),
    .issue_i     (issue),
    .req_i       (req),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== design/gbse_span_unit.sv =====
// gbse_span_unit: shared span builder, one span per request, with the output register
// depends on gbse_pkg (span_req_t, top_ones)
`timescale 1ns / 1ps
`default_nettype none

module gbse_span_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [gbse_pkg::CFG_DATA_W-1:0] scr_cols_i,
  input  wire logic [gbse_pkg::CFG_DATA_W-1:0] scr_rows_i,
  input  wire logic                           issue_i,
  input  wire gbse_pkg::span_req_t            req_i,
  output logic                                slot_free_o,
  gbse_out_if.source                          out_o
);
  import gbse_pkg::*;

  logic                 valid_q;
  logic [10:0]          x_q, y_q;
  logic [5:0]           w_q;
  logic [SPAN_BITS-1:0] pix_q, msk_q;
  logic [11:0]          nx_q;
  logic                 done_q;

  logic [6:0]           sum;
  logic [5:0]           w;
  logic [6:0]           gend_sum;
  logic [5:0]           gend;
  logic [5:0]           lead6;
  logic [SPAN_BITS-1:0] shifted, gmask, on_bits, wmask, pix;
  logic [11:0]          x0s, negx, hi_s;
  logic [5:0]           lo, hi;
  logic                 row_on;
  logic [SPAN_BITS-1:0] msk;
  logic [11:0]          nx;

  always_comb begin
    sum      = 7'(req_i.lead) + 7'(req_i.glyph) + 7'(req_i.trail);
    w        = (sum > 7'(SPAN_BITS)) ? 6'(SPAN_BITS) : sum[5:0];
    gend_sum = 7'(req_i.lead) + 7'(req_i.glyph);
    gend     = (gend_sum > 7'(SPAN_BITS)) ? 6'(SPAN_BITS) : gend_sum[5:0];
    lead6    = 6'(req_i.lead);

    // glyph bits land at columns lead .. lead+glyph-1, at most lead+31; other columns stay unset
    shifted = {req_i.bits, {(SPAN_BITS-ROW_BITS){1'b0}}} >> lead6;
    gmask   = top_ones(gend) & ~top_ones(lead6);
    on_bits = req_i.glyph_row ? (shifted & gmask) : '0;
    wmask   = top_ones(w);
    pix     = (on_bits ^ {SPAN_BITS{req_i.invert}}) & wmask;

    // visible columns: c in [-x0, scr_cols - x0), clipped to the span
    x0s  = {req_i.x0[10], req_i.x0};
    negx = 12'd0 - x0s;
    lo   = !req_i.x0[10] ? 6'd0 :
           ((negx > 12'(SPAN_BITS)) ? 6'(SPAN_BITS) : negx[5:0]);
    hi_s = {2'b00, scr_cols_i} - x0s;
    hi   = hi_s[11] ? 6'd0 :
           ((hi_s > 12'(SPAN_BITS)) ? 6'(SPAN_BITS) : hi_s[5:0]);
    row_on = !req_i.y[10] && (req_i.y[9:0] < scr_rows_i);
    msk    = row_on ? (top_ones(hi) & ~top_ones(lo) & wmask) : '0;

    nx = x0s + 12'(w);
  end

  assign slot_free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (issue_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      x_q    <= req_i.x0;
      y_q    <= req_i.y;
      w_q    <= w;
      pix_q  <= pix;
      msk_q  <= msk;
      nx_q   <= nx;
      done_q <= req_i.done;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.span_x      = x_q;
  assign out_o.span_y      = y_q;
  assign out_o.span_width  = w_q;
  assign out_o.span_pixels = pix_q;
  assign out_o.write_mask  = msk_q;
  assign out_o.next_x      = nx_q;
  assign out_o.glyph_done  = done_q;

endmodule

`default_nettype wire

// ===== design/gbse_sequencer.sv =====
// gbse_sequencer: latches glyph headers and steps through the rows above, the bitmap
// rows and the rows below, issuing one span request at a time; depends on gbse_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbse_sequencer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gbse_in_if.sink                  in_i,
  input  wire logic                slot_free_i,
  output logic                     issue_o,
  output gbse_pkg::span_req_t      req_o
);
  import gbse_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABOVE,
    ST_ROW,
    ST_BELOW
  } state_e;

  state_e              state_q, state_d;
  logic [10:0]         origin_x_q, row_y_q;
  logic [3:0]          lead_q, trail_q;
  logic [5:0]          glyph_q;
  logic [4:0]          rows_left_q;
  logic [3:0]          above_q, below_q;
  logic                invert_q;
  logic [ROW_BITS-1:0] bits_q;

  logic       accept;
  logic [3:0] above_in, below_in;
  logic       req_done;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign above_in   = clamp_pad(in_i.rows_above, 4'(MAX_PAD_ROWS));
  assign below_in   = clamp_pad(in_i.rows_below, 4'(MAX_PAD_ROWS));
  assign issue_o    = (state_q != ST_IDLE) && slot_free_i;

  always_comb begin
    case (state_q)
      ST_ABOVE: req_done = (above_q == 4'd1) && (rows_left_q == '0) && (below_q == '0);
      ST_ROW:   req_done = (rows_left_q == 5'd1) && (below_q == '0);
      ST_BELOW: req_done = (below_q == 4'd1);
      default:  req_done = 1'b0;
    endcase
  end

  assign req_o.x0        = origin_x_q;
  assign req_o.y         = row_y_q;
  assign req_o.lead      = lead_q;
  assign req_o.glyph     = glyph_q;
  assign req_o.trail     = trail_q;
  assign req_o.bits      = bits_q;
  assign req_o.glyph_row = (state_q == ST_ROW);
  assign req_o.invert    = invert_q;
  assign req_o.done      = req_done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.kind == KIND_HEADER) begin
            if (above_in != '0) begin
              state_d = ST_ABOVE;
            end else if (in_i.rows_glyph == '0 && below_in != '0) begin
              state_d = ST_BELOW;
            end
          end else if (rows_left_q != '0) begin
            state_d = ST_ROW;
          end
        end
      end
      ST_ABOVE: begin
        if (issue_o && above_q == 4'd1) begin
          state_d = (rows_left_q == '0 && below_q != '0) ? ST_BELOW : ST_IDLE;
        end
      end
      ST_ROW: begin
        if (issue_o) begin
          state_d = (rows_left_q == 5'd1 && below_q != '0) ? ST_BELOW : ST_IDLE;
        end
      end
      ST_BELOW: begin
        if (issue_o && below_q == 4'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      origin_x_q  <= '0;
      row_y_q     <= '0;
      lead_q      <= '0;
      glyph_q     <= '0;
      trail_q     <= '0;
      rows_left_q <= '0;
      above_q     <= '0;
      below_q     <= '0;
      invert_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_i.kind == KIND_HEADER) begin
        origin_x_q  <= in_i.pos_x;
        row_y_q     <= in_i.pos_y;
        lead_q      <= in_i.padding_flags[0] ?
                       clamp_pad(in_i.cols_before, 4'(MAX_PAD_COLS)) : 4'd0;
        glyph_q     <= (in_i.cols_glyph > 6'(MAX_GLYPH_COLS)) ?
                       6'(MAX_GLYPH_COLS) : in_i.cols_glyph;
        trail_q     <= in_i.padding_flags[1] ?
                       clamp_pad(in_i.cols_after, 4'(MAX_PAD_COLS)) : 4'd0;
        rows_left_q <= in_i.rows_glyph;
        above_q     <= above_in;
        below_q     <= below_in;
        invert_q    <= in_i.reverse_video;
      end
      if (issue_o) begin
        // row y wraps at 11 bits
        row_y_q <= row_y_q + 11'd1;
        case (state_q)
          ST_ABOVE: above_q     <= above_q - 4'd1;
          ST_ROW:   rows_left_q <= rows_left_q - 5'd1;
          ST_BELOW: below_q     <= below_q - 4'd1;
          default:  ;
        endcase
      end
    end
  end

  // bitmap word held for the row span
  always_ff @(posedge clk_i) begin
    if (accept && in_i.kind == KIND_ROW) begin
      bits_q <= in_i.row_bits;
    end
  end

  a_done_ends_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_o && req_o.done |=> state_q == ST_IDLE)
    else $error("final span did not return the sequencer to idle");

  a_above_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ABOVE |-> above_q != '0)
    else $error("rows-above phase with no rows left");

  a_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROW |-> rows_left_q != '0)
    else $error("bitmap row span with no bitmap rows pending");

  a_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BELOW |-> below_q != '0)
    else $error("rows-below phase with no rows left");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking bench for glyph_bitmap_span_expander_unit, glyph words in, span words out
// depends on gbse_pkg, the gbse_* channel interfaces and the design sources
`timescale 1ns / 1ps

module tb;
  import gbse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  typedef struct packed {
    logic          kind;
    logic [10:0]   pos_x;
    logic [10:0]   pos_y;
    logic [3:0]    cols_before;
    logic [5:0]    cols_glyph;
    logic [3:0]    cols_after;
    logic [3:0]    rows_above;
    logic [4:0]    rows_glyph;
    logic [3:0]    rows_below;
    logic          reverse_video;
    logic [1:0]    padding_flags;
    logic [31:0]   row_bits;
  } glyph_word_t;

  typedef struct packed {
    logic [10:0]          x;
    logic [10:0]          y;
    logic [5:0]           width;
    logic [SPAN_BITS-1:0] pixels;
    logic [SPAN_BITS-1:0] mask;
    logic [11:0]          next_x;
    logic                 done;
  } span_word_t;

  logic clk_i;
  logic rst_ni = 1'b1;

  gbse_in_if  in_if ();
  gbse_out_if out_if ();
  gbse_cfg_if cfg_if ();

  glyph_bitmap_span_expander_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  glyph_word_t words_to_send[$];
  span_word_t  spans_due[$];
  int          words_outstanding = 0;
  int          errors = 0;
  int          rand_words = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;
  int          in_gap;
  int          out_stall;
  glyph_word_t cur_word;

  // screen size and glyph state as the block should hold them
  logic [9:0]  scr_w;
  logic [9:0]  scr_h;
  logic [10:0] cell_x;
  logic [10:0] cell_row;
  logic [3:0]  lead_w;
  logic [5:0]  glyph_w;
  logic [3:0]  trail_w;
  logic [4:0]  rows_pending;
  logic [3:0]  rows_under;
  logic        invert;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic int sat(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one span of the current glyph at the current row, then step the row
  task automatic emit_span(input bit glyph_row, input logic [31:0] bits, input bit last);
    span_word_t s;
    int w, x0, y, c, g, sw, sh, nx;
    bit on;
    w = sat(lead_w + glyph_w + trail_w, SPAN_BITS);
    x0 = $signed(cell_x);
    y = $signed(cell_row);
    sw = scr_w;
    sh = scr_h;
    s = '0;
    s.x = cell_x;
    s.y = cell_row;
    s.width = 6'(w);
    for (c = 0; c < w; c++) begin
      on = 1'b0;
      if (glyph_row && c >= lead_w && c < lead_w + glyph_w) begin
        g = c - lead_w;
        if (g < ROW_BITS) on = bits[31 - g];
      end
      if (invert) on = !on;
      s.pixels[SPAN_BITS - 1 - c] = on;
      if (y >= 0 && y < sh && x0 + c >= 0 && x0 + c < sw) s.mask[SPAN_BITS - 1 - c] = 1'b1;
    end
    nx = x0 + w;
    s.next_x = 12'(nx);
    s.done = last;
    spans_due.push_back(s);
    cell_row = cell_row + 11'd1;
  endtask

  task automatic emit_rows_under();
    while (rows_under != 0) begin
      rows_under = rows_under - 4'd1;
      emit_span(1'b0, '0, rows_under == 0);
    end
  endtask

  task automatic expand_word(input glyph_word_t w);
    logic [3:0] above;
    if (w.kind == KIND_HEADER) begin
      above = 4'(sat(w.rows_above, MAX_PAD_ROWS));
      cell_x = w.pos_x;
      cell_row = w.pos_y;
      lead_w = w.padding_flags[0] ? 4'(sat(w.cols_before, MAX_PAD_COLS)) : 4'd0;
      glyph_w = 6'(sat(w.cols_glyph, MAX_GLYPH_COLS));
      trail_w = w.padding_flags[1] ? 4'(sat(w.cols_after, MAX_PAD_COLS)) : 4'd0;
      rows_pending = w.rows_glyph;
      rows_under = 4'(sat(w.rows_below, MAX_PAD_ROWS));
      invert = w.reverse_video;
      while (above != 0) begin
        above = above - 4'd1;
        emit_span(1'b0, '0, above == 0 && rows_pending == 0 && rows_under == 0);
      end
      if (rows_pending == 0) emit_rows_under();
    end else if (rows_pending != 0) begin
      rows_pending = rows_pending - 5'd1;
      emit_span(1'b1, w.row_bits, rows_pending == 0 && rows_under == 0);
      if (rows_pending == 0) emit_rows_under();
    end
  endtask

  task automatic put_word(input glyph_word_t w);
    in_if.kind <= w.kind;
    in_if.pos_x <= w.pos_x;
    in_if.pos_y <= w.pos_y;
    in_if.cols_before <= w.cols_before;
    in_if.cols_glyph <= w.cols_glyph;
    in_if.cols_after <= w.cols_after;
    in_if.rows_above <= w.rows_above;
    in_if.rows_glyph <= w.rows_glyph;
    in_if.rows_below <= w.rows_below;
    in_if.reverse_video <= w.reverse_video;
    in_if.padding_flags <= w.padding_flags;
    in_if.row_bits <= w.row_bits;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      put_word('0);
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expand_word(cur_word);
        words_outstanding--;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          cur_word = words_to_send.pop_front();
          put_word(cur_word);
          in_if.valid <= 1'b1;
          in_gap = idle_len();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t span mismatch on %s: expected %0h got %0h", $time, what, want, got);
    errors++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_word_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (spans_due.size() == 0) begin
          $display("%0t unexpected span: expected none got x %0h y %0h width %0d",
                   $time, $unsigned(out_if.span_x), $unsigned(out_if.span_y),
                   out_if.span_width);
          errors++;
        end else begin
          want = spans_due.pop_front();
          if (out_if.span_x !== want.x) report("span_x", want.x, $unsigned(out_if.span_x));
          if (out_if.span_y !== want.y) report("span_y", want.y, $unsigned(out_if.span_y));
          if (out_if.span_width !== want.width) report("span_width", want.width,
                                                       out_if.span_width);
          if (out_if.span_pixels !== want.pixels) report("span_pixels", want.pixels,
                                                         out_if.span_pixels);
          if (out_if.write_mask !== want.mask) report("write_mask", want.mask,
                                                      out_if.write_mask);
          if (out_if.next_x !== want.next_x) report("next_x", want.next_x,
                                                    $unsigned(out_if.next_x));
          if (out_if.glyph_done !== want.done) report("glyph_done", want.done,
                                                      out_if.glyph_done);
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) out_stall = idle_len();
      end
    end
  end

  task automatic queue_word(input glyph_word_t w);
    words_to_send.push_back(w);
    words_outstanding++;
  endtask

  function automatic glyph_word_t header_word(input int x, input int y, input int cb,
                                              input int cg, input int ca, input int ra,
                                              input int rg, input int rb, input int rv,
                                              input int pf);
    glyph_word_t w;
    w = '0;
    w.kind = KIND_HEADER;
    w.pos_x = 11'(x);
    w.pos_y = 11'(y);
    w.cols_before = 4'(cb);
    w.cols_glyph = 6'(cg);
    w.cols_after = 4'(ca);
    w.rows_above = 4'(ra);
    w.rows_glyph = 5'(rg);
    w.rows_below = 4'(rb);
    w.reverse_video = 1'(rv);
    w.padding_flags = 2'(pf);
    return w;
  endfunction

  function automatic glyph_word_t row_word(input logic [31:0] bits);
    glyph_word_t w;
    w = '0;
    w.kind = KIND_ROW;
    w.row_bits = bits;
    return w;
  endfunction

  // every field random, so ignored header fields of row words toggle too
  function automatic glyph_word_t random_word();
    glyph_word_t w;
    w.kind = 1'($urandom_range(0, 1));
    w.pos_x = 11'($urandom);
    w.pos_y = 11'($urandom);
    w.cols_before = 4'($urandom);
    w.cols_glyph = 6'($urandom);
    w.cols_after = 4'($urandom);
    w.rows_above = 4'($urandom);
    w.rows_glyph = 5'($urandom);
    w.rows_below = 4'($urandom);
    w.reverse_video = 1'($urandom);
    w.padding_flags = 2'($urandom);
    case ($urandom_range(0, 9))
      0: w.row_bits = '0;
      1: w.row_bits = '1;
      default: w.row_bits = $urandom;
    endcase
    return w;
  endfunction

  // header mostly near the visible screen, with in-range metrics and few rows
  function automatic glyph_word_t random_header();
    glyph_word_t w;
    int v, r;
    w = random_word();
    w.kind = KIND_HEADER;
    if ($urandom_range(0, 9) < 7) begin
      v = $urandom_range(0, scr_w + 60) - 40;
      w.pos_x = 11'(v);
    end
    r = $urandom_range(0, 19);
    if (r < 12) begin
      v = $urandom_range(0, scr_h + 40) - 20;
      w.pos_y = 11'(v);
    end else if (r < 15) begin
      w.pos_y = 11'($urandom_range(1010, 1023));
    end
    if ($urandom_range(0, 6) != 0) begin
      w.cols_before = 4'($urandom_range(0, MAX_PAD_COLS));
      w.cols_glyph = 6'($urandom_range(0, MAX_GLYPH_COLS));
      w.cols_after = 4'($urandom_range(0, MAX_PAD_COLS));
    end
    if ($urandom_range(0, 9) < 7) w.rows_above = 4'($urandom_range(0, 2));
    if ($urandom_range(0, 9) < 7) w.rows_below = 4'($urandom_range(0, 2));
    r = $urandom_range(0, 19);
    if (r < 16) w.rows_glyph = 5'($urandom_range(0, 5));
    else if (r < 19) w.rows_glyph = 5'($urandom_range(6, 12));
    return w;
  endfunction

  // a glyph sequence; now and then cut short by the next header or followed by a stray row
  task automatic random_glyph();
    glyph_word_t h, r;
    int rows, k;
    h = random_header();
    queue_word(h);
    rand_words++;
    rows = h.rows_glyph;
    if (rows != 0 && $urandom_range(0, 9) == 0) rows = $urandom_range(0, rows - 1);
    for (k = 0; k < rows; k++) begin
      r = random_word();
      r.kind = KIND_ROW;
      queue_word(r);
      rand_words++;
    end
    if (rows == h.rows_glyph && $urandom_range(0, 14) == 0) begin
      r = random_word();
      r.kind = KIND_ROW;
      queue_word(r);
    end
  endtask

  task automatic settle();
    while (words_outstanding != 0 || spans_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SCR_COLS: scr_w = val;
      REG_SCR_ROWS: scr_h = val;
      default: ;
    endcase
  endtask

  initial begin
    int p, sw, sh, target;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    rst_ni <= 1'b0;
    scr_w = SCR_COLS_RST;
    scr_h = SCR_ROWS_RST;
    cell_x = '0;
    cell_row = '0;
    lead_w = '0;
    glyph_w = '0;
    trail_w = '0;
    rows_pending = '0;
    rows_under = '0;
    invert = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed glyphs on the reset screen size
    queue_word(header_word(2, 3, 2, 8, 2, 1, 2, 1, 0, 3));
    queue_word(row_word(32'hFFFF_FFFF));
    queue_word(row_word(32'hA500_0000));
    // hidden padding with reverse video
    queue_word(header_word(100, 10, 5, 12, 3, 0, 1, 0, 1, 0));
    queue_word(row_word(32'h8000_0001));
    // oversized metrics at the bottom right corner
    queue_word(header_word(390, 230, 15, 63, 15, 15, 1, 15, 0, 3));
    queue_word(row_word(32'hFFFF_FFFF));
    // empty glyph, then a stray row
    queue_word(header_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_word(row_word(32'h1234_5678));
    // no bitmap rows, off the top left
    queue_word(header_word(-5, -2, 8, 32, 8, 2, 0, 2, 1, 1));
    // glyph abandoned by the next header, which wraps below the last row
    queue_word(header_word(50, 50, 0, 32, 8, 0, 3, 2, 0, 2));
    queue_word(row_word(32'hDEAD_BEEF));
    queue_word(header_word(1023, 1023, 0, 32, 8, 0, 2, 1, 0, 3));
    queue_word(row_word(32'h0000_FFFF));
    queue_word(row_word(32'hFFFF_0000));
    // most negative cell, glyph just wider than the source word
    queue_word(header_word(-1024, -1024, 8, 33, 8, 1, 1, 0, 1, 3));
    queue_word(row_word(32'hFFFF_FFFF));
    // rows above running up to row 1023, the last positive row
    queue_word(header_word(20, 1021, 0, 4, 0, 3, 0, 0, 0, 0));
    // right and bottom screen edges
    queue_word(header_word(398, 239, 0, 4, 0, 0, 1, 1, 0, 0));
    queue_word(row_word(32'hF000_0000));
    queue_word(row_word(32'hFFFF_FFFF));

    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          sw = 1023;
          sh = 1023;
        end
        1: begin
          sw = 1;
          sh = 1;
        end
        2: begin
          sw = 0;
          sh = $urandom_range(0, 1023);
        end
        3: begin
          sw = 40;
          sh = 24;
        end
        default: begin
          sw = $urandom_range(1, 1023);
          sh = $urandom_range(1, 1023);
        end
      endcase
      write_reg(REG_SCR_COLS, CFG_DATA_W'(sw));
      write_reg(REG_SCR_ROWS, CFG_DATA_W'(sh));
      if (p == 3) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      cfg_if.valid <= 1'b0;
      no_idle = (p == 4);
      target = rand_words + WORDS_PER_PHASE;
      while (rand_words < target) random_glyph();
    end

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
